### hdl/mpcq_pkg.sv
// Shared types and constants for the min-priority command queue.
`timescale 1ns / 1ps
package mpcq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W = 5;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] handle;
	} entry_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  item_priority;
		logic [15:0] item_handle;
	} cmd_t;

	typedef struct packed {
		logic [15:0]      out_handle;
		logic [7:0]       out_priority;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

### hdl/mpcq_store.sv
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module mpcq_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [mpcq_pkg::IDX_W-1:0]  waddr,
	input  mpcq_pkg::entry_t            wdata,
	input  logic [mpcq_pkg::IDX_W-1:0]  raddr,
	output mpcq_pkg::entry_t            rdata
);
	import mpcq_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/min_priority_command_queue.sv
// Min-priority command queue: sorted entry store walked by a small sequencer.
// Enqueue writes directly when empty, else ENQ_CMP moves larger entries up, ENQ_PUT may
// fill slot 0; dequeue reads in DEQ_HEAD, shifts in DEQ_SHIFT; refusals finish from idle.
// Throughput: busy drops as the result is formed, so the next start may be taken
// in the cycle that done is high. One store read and one write a cycle set the pace.
// Reset: arst_n clears the entry count, the sequencer and done; entries are not cleared.
`timescale 1ns / 1ps
module min_priority_command_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mpcq_pkg::cmd_t    cmd,
	output logic              done,
	output mpcq_pkg::result_t result
);
	import mpcq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE      = 5'b00001,
		S_ENQ_CMP   = 5'b00010,
		S_ENQ_PUT   = 5'b00100,
		S_DEQ_HEAD  = 5'b01000,
		S_DEQ_SHIFT = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	entry_t           item_q, item_d;
	entry_t           front_q, front_d;
	logic             done_q;
	result_t          res_q;

	logic             fin;
	result_t          fin_res;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	logic [CNT_W-1:0] cnt_m1, cnt_p1, pos_m1, pos_m2, pos_p1, pos_p2;
	entry_t           new_entry;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_p1 = cnt_q + CNT_W'(1);
	assign pos_m1 = pos_q - CNT_W'(1);
	assign pos_m2 = pos_q - CNT_W'(2);
	assign pos_p1 = pos_q + CNT_W'(1);
	assign pos_p2 = pos_q + CNT_W'(2);

	assign new_entry.prio   = cmd.item_priority;
	assign new_entry.handle = cmd.item_handle;

	mpcq_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		item_d    = item_q;
		front_d   = front_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q[IDX_W-1:0];
		mem_wdata = item_q;
		mem_raddr = '0;
		fin       = 1'b0;
		fin_res   = '0;
		fin_res.status = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					item_d = new_entry;
					if (cmd.operation == OP_ENQUEUE) begin
						if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
							fin = 1'b1;
							fin_res.status    = ST_FULL;
							fin_res.occupancy = OCC_W'(cnt_q);
						end else if (cnt_q == '0) begin
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = new_entry;
							cnt_d     = cnt_p1;
							fin       = 1'b1;
							fin_res.occupancy = OCC_W'(cnt_p1);
						end else begin
							mem_raddr = cnt_m1[IDX_W-1:0];
							pos_d     = cnt_q;
							state_d   = S_ENQ_CMP;
						end
					end else begin
						if (cnt_q == '0) begin
							fin = 1'b1;
							fin_res.status = ST_EMPTY;
						end else begin
							mem_raddr = '0;
							state_d   = S_DEQ_HEAD;
						end
					end
				end
			end
			S_ENQ_CMP: begin
				mem_we = 1'b1;
				if (mem_rdata.prio > item_q.prio) begin
					// move the larger entry up one place and look further down
					mem_wdata = mem_rdata;
					pos_d     = pos_m1;
					if (pos_q == CNT_W'(1)) begin
						state_d = S_ENQ_PUT;
					end else begin
						mem_raddr = pos_m2[IDX_W-1:0];
					end
				end else begin
					cnt_d   = cnt_p1;
					fin     = 1'b1;
					fin_res.occupancy = OCC_W'(cnt_p1);
					state_d = S_IDLE;
				end
			end
			S_ENQ_PUT: begin
				mem_we  = 1'b1;
				cnt_d   = cnt_p1;
				fin     = 1'b1;
				fin_res.occupancy = OCC_W'(cnt_p1);
				state_d = S_IDLE;
			end
			S_DEQ_HEAD: begin
				front_d = mem_rdata;
				cnt_d   = cnt_m1;
				pos_d   = '0;
				if (cnt_m1 == '0) begin
					fin = 1'b1;
					fin_res.out_handle   = mem_rdata.handle;
					fin_res.out_priority = mem_rdata.prio;
					fin_res.occupancy    = OCC_W'(cnt_m1);
					state_d = S_IDLE;
				end else begin
					mem_raddr = IDX_W'(1);
					state_d   = S_DEQ_SHIFT;
				end
			end
			S_DEQ_SHIFT: begin
				// count already holds the reduced value here
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				if (pos_p1 < cnt_q) begin
					mem_raddr = pos_p2[IDX_W-1:0];
					pos_d     = pos_p1;
				end else begin
					fin = 1'b1;
					fin_res.out_handle   = front_q.handle;
					fin_res.out_priority = front_q.prio;
					fin_res.occupancy    = OCC_W'(cnt_q);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		item_q  <= item_d;
		front_q <= front_d;
		if (fin) begin
			res_q <= fin_res;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
